[hw/rtl/current_coulomb_counter_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the current coulomb counter
// Each macro expands to a concurrent assertion clocked by clk and disabled
// while arst_n is low. Synthesis sees empty bodies.
// ---------------------------------------------------------------------------
`ifndef CURRENT_COULOMB_COUNTER_MACROS_SVH
`define CURRENT_COULOMB_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CCC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCC_ASSERT_IMPLIES(label, ante, cons, msg)
`define CCC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/ccc_pkg.sv]
// ---------------------------------------------------------------------------
// ccc_pkg
// Shared types and fixed constants of the current coulomb counter.
// ---------------------------------------------------------------------------
package ccc_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_STEP_UV     = 2'd0,
		REG_SLOPE       = 2'd1,
		REG_OFFSET      = 2'd2,
		REG_SAVE_PERIOD = 2'd3
	} ccc_reg_t;

	localparam logic [9:0]  STEP_UV_RST     = 10'd188;
	localparam logic [15:0] SLOPE_RST       = 16'd7705;
	localparam logic [15:0] OFFSET_RST      = 16'd3884;
	localparam logic [15:0] SAVE_PERIOD_RST = 16'd10000;

	localparam logic [15:0] CURRENT_MAX_MA = 16'd50000;
	localparam logic [15:0] CAPACITY_LIMIT = 16'd36000;
	localparam logic [19:0] UAS_PER_AS     = 20'd1000000;
	localparam logic [35:0] CHARGE_MAX     = 36'd65535999999;
	localparam logic [16:0] TIMER_MAX      = 17'd131071;

	// divide by 10^6 = 2^6 * 15625: shift, then reciprocal multiply and one fix-up
	localparam int          DIV_SHIFT   = 6;
	localparam logic [13:0] DIV_BASE    = 14'd15625;
	localparam int          RECIP_SHIFT = 31;
	localparam logic [17:0] RECIP       = 18'd137438;

	// one-cycle datapath commands from the controller
	typedef struct packed {
		logic load_in;         // capture the input request
		logic mul_uv;          // code times step
		logic mul_slope;       // microvolts times slope
		logic div_mul;         // reciprocal multiply
		logic div_fix;         // remainder check and quotient fix-up
		logic div_src_charge;  // divider works on the charge, else on the product
		logic mul_time;        // current times elapsed time
		logic accum;           // charge and save timer update
		logic load_cap;        // load a new capacity
		logic out_load;        // move the result into the output register
	} ccc_cmd_t;

endpackage

[hw/rtl/ccc_ctrl.sv]
// ---------------------------------------------------------------------------
// ccc_ctrl
// Sequencer of the coulomb counter: steps the datapath through one request
// and owns both handshakes.
// ---------------------------------------------------------------------------
`include "current_coulomb_counter_macros.svh"

module ccc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic              action,
	output logic              result_valid,
	input  logic              result_stall,
	output ccc_pkg::ccc_cmd_t cmd
);
	import ccc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UV,
		ST_SLOPE,
		ST_RAW_MUL,
		ST_RAW_FIX,
		ST_TIME,
		ST_ACCUM,
		ST_LOAD,
		ST_CAP_MUL,
		ST_CAP_FIX,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   accept;
	logic   out_free;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && (state_q == ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:    cmd.load_in = accept;
			ST_UV:      cmd.mul_uv = 1'b1;
			ST_SLOPE:   cmd.mul_slope = 1'b1;
			ST_RAW_MUL: cmd.div_mul = 1'b1;
			ST_RAW_FIX: cmd.div_fix = 1'b1;
			ST_TIME:    cmd.mul_time = 1'b1;
			ST_ACCUM:   cmd.accum = 1'b1;
			ST_LOAD:    cmd.load_cap = 1'b1;
			ST_CAP_MUL: begin
				cmd.div_mul        = 1'b1;
				cmd.div_src_charge = 1'b1;
			end
			ST_CAP_FIX: begin
				cmd.div_fix        = 1'b1;
				cmd.div_src_charge = 1'b1;
			end
			ST_OUT:     cmd.out_load = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken at this edge
			if ((state_q == ST_OUT) && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= action ? ST_LOAD : ST_UV;
				end
				ST_UV:      state_q <= ST_SLOPE;
				ST_SLOPE:   state_q <= ST_RAW_MUL;
				ST_RAW_MUL: state_q <= ST_RAW_FIX;
				ST_RAW_FIX: state_q <= ST_TIME;
				ST_TIME:    state_q <= ST_ACCUM;
				ST_ACCUM:   state_q <= ST_CAP_MUL;
				ST_LOAD:    state_q <= ST_CAP_MUL;
				ST_CAP_MUL: state_q <= ST_CAP_FIX;
				ST_CAP_FIX: state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	`CCC_ASSERT_NEXT(a_accept_goes_busy, sample_valid && !sample_stall, sample_stall, "accepted request did not start the sequence")
	`CCC_ASSERT_NEXT(a_out_waits, (state_q == ST_OUT) && result_valid_q && result_stall, (state_q == ST_OUT) && result_valid_q, "result dropped while output register was full")
	`CCC_ASSERT_IMPLIES(a_one_command, 1'b1, $onehot0({cmd.load_in, cmd.mul_uv, cmd.mul_slope, cmd.div_mul, cmd.div_fix, cmd.mul_time, cmd.accum, cmd.load_cap, cmd.out_load}), "more than one datapath command in a cycle")

endmodule

[hw/rtl/ccc_datapath.sv]
// ---------------------------------------------------------------------------
// ccc_datapath
// Configuration registers, multipliers, shared divide-by-10^6 unit, charge
// accumulator, save timer and output register of the coulomb counter.
// ---------------------------------------------------------------------------
`include "current_coulomb_counter_macros.svh"

module ccc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ccc_pkg::ccc_cmd_t cmd,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic signed [15:0] adc_code,
	input  logic [15:0]       elapsed_ms,
	input  logic [15:0]       new_capacity,
	output logic [15:0]       current_ma,
	output logic [15:0]       capacity_as,
	output logic              save_request
);
	import ccc_pkg::*;

	// configuration
	logic [9:0]  step_uv_q;
	logic [15:0] slope_q;
	logic [15:0] offset_q;
	logic [15:0] period_q;

	// captured request
	logic signed [15:0] code_q;
	logic [15:0]        elapsed_q;
	logic [15:0]        new_cap_q;

	// working registers
	logic [24:0] uv_q;
	logic [40:0] prod_q;
	logic [30:0] divx_q;
	logic [17:0] q0_q;
	logic [15:0] current_q;
	logic [15:0] cap_q;
	logic [31:0] add_q;
	logic [35:0] charge_q;
	logic [16:0] timer_q;
	logic        save_q;

	logic [15:0] current_ma_q;
	logic [15:0] capacity_as_q;
	logic        save_request_q;

	logic [14:0] code_clamp;
	logic [30:0] div_x;
	logic [48:0] recip_prod;
	logic [31:0] back_prod;
	logic [31:0] rem_full;
	logic [14:0] rem;
	logic [17:0] quot;
	logic [17:0] diff;
	logic [15:0] current_next;
	logic [36:0] charge_sum;
	logic [17:0] timer_sum;
	logic [16:0] timer_sat;
	logic [15:0] cap_clamp;

	assign code_clamp = code_q[15] ? '0 : code_q[14:0];

	// shift by 2^6; products too large for any current past the clamp saturate
	always_comb begin
		if (cmd.div_src_charge)
			div_x = {1'b0, charge_q[35:DIV_SHIFT]};
		else if (|prod_q[40:37])
			div_x = '1;
		else
			div_x = prod_q[36:DIV_SHIFT];
	end

	assign recip_prod = 49'(div_x) * 49'(RECIP);
	assign back_prod  = 32'(q0_q) * 32'(DIV_BASE);
	assign rem_full   = {1'b0, divx_q} - back_prod;
	assign rem        = rem_full[14:0];
	// reciprocal estimate is low by at most one
	assign quot       = q0_q + 18'(rem >= 15'(DIV_BASE));

	always_comb begin
		diff         = quot - {2'b00, offset_q};
		current_next = '0;
		if (quot > {2'b00, offset_q})
			current_next = (diff > {2'b00, CURRENT_MAX_MA}) ? CURRENT_MAX_MA : diff[15:0];
	end

	assign charge_sum = {1'b0, charge_q} + {5'b0, add_q};
	assign timer_sum  = {1'b0, timer_q} + {2'b00, elapsed_q};
	assign timer_sat  = (timer_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : timer_sum[16:0];
	assign cap_clamp  = (new_cap_q > CAPACITY_LIMIT) ? CAPACITY_LIMIT : new_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_uv_q <= STEP_UV_RST;
			slope_q   <= SLOPE_RST;
			offset_q  <= OFFSET_RST;
			period_q  <= SAVE_PERIOD_RST;
			charge_q  <= '0;
			timer_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_STEP_UV:     step_uv_q <= cfg_data[9:0];
					REG_SLOPE:       slope_q   <= cfg_data;
					REG_OFFSET:      offset_q  <= cfg_data;
					REG_SAVE_PERIOD: period_q  <= cfg_data;
					default:         ;
				endcase
			end
			if (cmd.accum) begin
				charge_q <= (charge_sum > {1'b0, CHARGE_MAX}) ? CHARGE_MAX : charge_sum[35:0];
				if (timer_sat > {1'b0, period_q})
					timer_q <= '0;
				else
					timer_q <= timer_sat;
			end
			if (cmd.load_cap)
				charge_q <= 36'(cap_clamp) * 36'(UAS_PER_AS);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			code_q    <= adc_code;
			elapsed_q <= elapsed_ms;
			new_cap_q <= new_capacity;
		end
		if (cmd.mul_uv)
			uv_q <= 25'(code_clamp) * 25'(step_uv_q);
		if (cmd.mul_slope)
			prod_q <= 41'(uv_q) * 41'(slope_q);
		if (cmd.div_mul) begin
			divx_q <= div_x;
			q0_q   <= recip_prod[48:RECIP_SHIFT];
		end
		if (cmd.div_fix) begin
			if (cmd.div_src_charge)
				cap_q <= quot[15:0];
			else
				current_q <= current_next;
		end
		if (cmd.mul_time)
			add_q <= 32'(elapsed_q) * 32'(current_q);
		if (cmd.accum)
			save_q <= (timer_sat > {1'b0, period_q});
		if (cmd.load_cap) begin
			save_q    <= 1'b1;
			current_q <= '0;
		end
		if (cmd.out_load) begin
			current_ma_q   <= current_q;
			capacity_as_q  <= cap_q;
			save_request_q <= save_q;
		end
	end

	assign current_ma   = current_ma_q;
	assign capacity_as  = capacity_as_q;
	assign save_request = save_request_q;

	`CCC_ASSERT_IMPLIES(a_charge_bounded, 1'b1, charge_q <= CHARGE_MAX, "charge accumulator above its saturation value")
	`CCC_ASSERT_NEXT(a_current_bounded, cmd.div_fix && !cmd.div_src_charge, current_q <= CURRENT_MAX_MA, "current above its clamp")
	`CCC_ASSERT_NEXT(a_load_saves, cmd.load_cap, save_q && (current_q == 16'd0), "capacity load did not request a save")

endmodule

[hw/rtl/current_coulomb_counter.sv]
// Sample request: code times step, times slope, divide-by-10^6, offset and clamp,
// times elapsed time, charge update, divide of the charge, output. Load request:
// capacity load, divide of the charge, output. Requests stall until the sequencer
// is idle. The divider is shared; a stalled result register holds the last step.
// Reset (arst_n low) clears charge, save timer and handshakes at once and
// returns the configuration registers to their default values.
// ---------------------------------------------------------------------------
// current_coulomb_counter
// Integrating current meter: ADC code to milliamps, charge in ampere-seconds,
// periodic save requests and capacity loads.
// ---------------------------------------------------------------------------
module current_coulomb_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic              action,
	input  logic signed [15:0] adc_code,
	input  logic [15:0]       elapsed_ms,
	input  logic [15:0]       new_capacity,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [15:0]       current_ma,
	output logic [15:0]       capacity_as,
	output logic              save_request
);
	import ccc_pkg::*;

	ccc_cmd_t cmd;

	// registers may be written in any cycle
	assign cfg_ready = 1'b1;

	ccc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.action       (action),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	ccc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.adc_code     (adc_code),
		.elapsed_ms   (elapsed_ms),
		.new_capacity (new_capacity),
		.current_ma   (current_ma),
		.capacity_as  (capacity_as),
		.save_request (save_request)
	);

endmodule

[tb/tb_current_coulomb_counter.sv]
// ---------------------------------------------------------------------------
// tb_current_coulomb_counter
// Drives sample and load requests into the coulomb counter under several
// register settings and idle patterns. A local model of the meter predicts
// every result, and each accepted result is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_current_coulomb_counter;
	import ccc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 20;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int MAX_REPORTS   = 40;
	localparam int NUM_SEGMENTS  = 8;
	localparam int SEGMENT_ITEMS = 190;
	localparam int NUM_DIRECTED  = 25;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_LOAD   = 1'b1;

	localparam logic [63:0] MICRO          = 64'd1000000;
	localparam logic [63:0] FULL_SCALE_MA  = 64'd50000;
	localparam logic [63:0] LOAD_LIMIT_AS  = 64'd36000;
	localparam logic [63:0] CHARGE_CEILING = 64'd65535999999;
	localparam logic [63:0] TIMER_CEILING  = 64'd131071;

	typedef struct packed {
		logic [15:0] current;
		logic [15:0] capacity;
		logic        save;
	} meter_reading_t;

	typedef struct packed {
		logic           act;
		logic [15:0]    code;
		logic [15:0]    elapsed;
		logic [15:0]    cap;
		logic           known;
		meter_reading_t reading;
	} stim_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = REG_STEP_UV;
	logic [15:0] cfg_data     = 16'd0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic        action       = ACT_SAMPLE;
	logic signed [15:0] adc_code = 16'sd0;
	logic [15:0] elapsed_ms   = 16'd0;
	logic [15:0] new_capacity = 16'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] current_ma;
	logic [15:0] capacity_as;
	logic        save_request;

	// local copy of the meter state and its registers
	logic [9:0]  step_uv;
	logic [15:0] slope_ma_per_v;
	logic [15:0] offset_ma;
	logic [15:0] save_period_ms;
	logic [35:0] charge_uas;
	logic [16:0] save_timer_ms;

	meter_reading_t pending_readings[$];

	int idle_pct      = 0;
	int stall_pct     = 0;
	int error_count   = 0;
	int sample_count  = 0;
	int load_count    = 0;
	int reg_writes    = 0;
	int saves_seen    = 0;
	int full_scale    = 0;
	int saturated     = 0;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{ACT_SAMPLE, 16'h0000, 16'd0,     16'd0,     1'b1, '{16'd0, 16'd0,     1'b0}},
		'{ACT_SAMPLE, 16'h8000, 16'd100,   16'd0,     1'b1, '{16'd0, 16'd0,     1'b0}},
		'{ACT_SAMPLE, 16'hFFFF, 16'd1,     16'hFFFF,  1'b1, '{16'd0, 16'd0,     1'b0}},
		'{ACT_SAMPLE, 16'h0001, 16'hFFFF,  16'd0,     1'b1, '{16'd0, 16'd0,     1'b1}},
		'{ACT_SAMPLE, 16'h7FFF, 16'd1000,  16'd0,     1'b0, '0},
		'{ACT_LOAD,   16'h7FFF, 16'hFFFF,  16'hFFFF,  1'b1, '{16'd0, 16'd36000, 1'b1}},
		'{ACT_LOAD,   16'h0000, 16'd0,     16'd36001, 1'b1, '{16'd0, 16'd36000, 1'b1}},
		'{ACT_LOAD,   16'h0000, 16'd0,     16'd36000, 1'b1, '{16'd0, 16'd36000, 1'b1}},
		'{ACT_LOAD,   16'h8000, 16'd0,     16'd0,     1'b1, '{16'd0, 16'd0,     1'b1}},
		'{ACT_LOAD,   16'h0000, 16'd0,     16'd36000, 1'b1, '{16'd0, 16'd36000, 1'b1}},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h7FFF, 16'hFFFF,  16'd0,     1'b0, '0},
		'{ACT_SAMPLE, 16'h5555, 16'hAAAA,  16'hAAAA,  1'b0, '0},
		'{ACT_SAMPLE, 16'h2AAA, 16'h5555,  16'h5555,  1'b0, '0},
		'{ACT_LOAD,   16'h0000, 16'd0,     16'd1,     1'b1, '{16'd0, 16'd1,     1'b1}}
	};

	current_coulomb_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.action       (action),
		.adc_code     (adc_code),
		.elapsed_ms   (elapsed_ms),
		.new_capacity (new_capacity),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.current_ma   (current_ma),
		.capacity_as  (capacity_as),
		.save_request (save_request)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// Advance the meter by one request and return the reading it must produce.
	function automatic meter_reading_t predict_reading(input logic act,
			input logic [15:0] code, input logic [15:0] el, input logic [15:0] cap);
		meter_reading_t r;
		logic [63:0] uv;
		logic [63:0] raw;
		logic [63:0] amps;
		logic [63:0] add;
		logic [63:0] charge;
		logic [63:0] timer;
		r = '0;
		charge = 64'(charge_uas);
		if (act == ACT_LOAD) begin
			charge = ((64'(cap) > LOAD_LIMIT_AS) ? LOAD_LIMIT_AS : 64'(cap)) * MICRO;
			r.save = 1'b1;
		end else begin
			// negative codes read as zero volts
			uv = code[15] ? 64'd0 : 64'(code[14:0]) * 64'(step_uv);
			raw = (uv * 64'(slope_ma_per_v)) / MICRO;
			if (raw <= 64'(offset_ma)) begin
				amps = 64'd0;
			end else begin
				amps = raw - 64'(offset_ma);
				if (amps > FULL_SCALE_MA) begin
					amps = FULL_SCALE_MA;
				end
			end
			r.current = amps[15:0];
			add = 64'(el) * amps;
			if (charge > CHARGE_CEILING || add > CHARGE_CEILING - charge) begin
				charge = CHARGE_CEILING;
			end else begin
				charge = charge + add;
			end
			timer = 64'(save_timer_ms) + 64'(el);
			if (timer > TIMER_CEILING) begin
				timer = TIMER_CEILING;
			end
			if (timer > 64'(save_period_ms)) begin
				r.save = 1'b1;
				timer = 64'd0;
			end
			save_timer_ms = timer[16:0];
		end
		charge_uas = charge[35:0];
		r.capacity = 16'(charge / MICRO);
		return r;
	endfunction

	// Leaves cfg_valid high so that back-to-back writes follow each other without a gap.
	task automatic write_register(input ccc_reg_t idx, input logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STEP_UV:     step_uv = data[9:0];
			REG_SLOPE:       slope_ma_per_v = data;
			REG_OFFSET:      offset_ma = data;
			REG_SAVE_PERIOD: save_period_ms = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [15:0] step, input logic [15:0] slope,
			input logic [15:0] offset, input logic [15:0] period);
		write_register(REG_STEP_UV, step);
		write_register(REG_SLOPE, slope);
		write_register(REG_OFFSET, offset);
		write_register(REG_SAVE_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	// Hold off new requests until every pending result is back.
	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_request(input logic act, input logic [15:0] code,
			input logic [15:0] el, input logic [15:0] cap, input logic known,
			input meter_reading_t typed);
		meter_reading_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		action <= act;
		adc_code <= code;
		elapsed_ms <= el;
		new_capacity <= cap;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		predicted = predict_reading(act, code, el, cap);
		pending_readings.push_back(known ? typed : predicted);
		if (act == ACT_LOAD) load_count++;
		else sample_count++;
	endtask

	task automatic send_random_request();
		logic        act;
		logic [15:0] code;
		logic [15:0] el;
		logic [15:0] cap;
		act = ($urandom_range(11) == 0) ? ACT_LOAD : ACT_SAMPLE;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: code = 16'h8000;
					1: code = 16'hFFFF;
					2: code = 16'h0000;
					3: code = 16'h0001;
					default: code = 16'h7FFF;
				endcase
			end
			1, 2, 3: code = 16'($urandom);
			default: code = 16'($urandom_range(32767));
		endcase
		case ($urandom_range(9))
			0: el = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			1, 2: el = 16'($urandom);
			default: el = 16'($urandom_range(2000));
		endcase
		case ($urandom_range(7))
			0: cap = LOAD_LIMIT_AS[15:0] + 16'($urandom_range(1));
			1: cap = 16'd0;
			default: cap = 16'($urandom);
		endcase
		send_request(act, code, el, cap, 1'b0, '0);
	endtask

	always @(posedge clk) begin : result_check
		meter_reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: current %0d capacity %0d save %0d",
					current_ma, capacity_as, save_request));
			end else begin
				want = pending_readings.pop_front();
				if (current_ma !== want.current)
					report_mismatch($sformatf("current_ma got %0d, expected %0d",
						current_ma, want.current));
				if (capacity_as !== want.capacity)
					report_mismatch($sformatf("capacity_as got %0d, expected %0d",
						capacity_as, want.capacity));
				if (save_request !== want.save)
					report_mismatch($sformatf("save_request got %0d, expected %0d",
						save_request, want.save));
			end
			if (save_request === 1'b1) saves_seen++;
			if (current_ma == FULL_SCALE_MA[15:0]) full_scale++;
			if (capacity_as == 16'hFFFF) saturated++;
		end
	end

	initial begin
		step_uv = STEP_UV_RST;
		slope_ma_per_v = SLOPE_RST;
		offset_ma = OFFSET_RST;
		save_period_ms = SAVE_PERIOD_RST;
		charge_uas = '0;
		save_timer_ms = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_request(directed_rows[i].act, directed_rows[i].code, directed_rows[i].elapsed,
				directed_rows[i].cap, directed_rows[i].known, directed_rows[i].reading);
		end

		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			if (seg > 0) begin
				drain();
				case (seg)
					1: configure(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
					2: configure(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
					3: configure(16'd188, 16'd7705, 16'd3884, 16'd10000);
					default: begin
						if (seg % 2 == 0)
							configure(16'($urandom), 16'($urandom), 16'($urandom),
								16'($urandom));
						else
							configure(16'($urandom_range(1023)), 16'($urandom_range(20000)),
								16'($urandom_range(8000)), 16'($urandom_range(30000)));
					end
				endcase
			end
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if ($urandom_range(59) == 0) drain();
				send_random_request();
			end
		end

		drain();
		$display("Covered %0d sample and %0d load requests, %0d register writes, four idle patterns.",
			sample_count, load_count, reg_writes);
		$display("Saw %0d save requests, %0d full scale currents, %0d saturated charge readings.",
			saves_seen, full_scale, saturated);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results pending", pending_readings.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
